>>> hdl/lob_pkg.sv
// Shared widths, codes and defaults for the limit order book engine.
// No dependencies; compile first.
package lob_pkg;

  localparam int ORDER_CAP_DEF    = 4096;
  localparam int PRICE_LEVELS_DEF = 4096;

  localparam int KEY_W   = 16;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int TOT_W   = 43;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Bitmap group size for the best-level search
  localparam int GRP_BITS = 64;

  localparam logic [PRICE_W-1:0] LOWEST_RST  = 32'd0;
  localparam logic [PRICE_W-1:0] HIGHEST_RST = 32'd4095;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_MOD    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_BAD_PRICE = 3'd2,
    ST_NOT_LIVE  = 3'd3,
    ST_POOL_FULL = 3'd4,
    ST_LIVE      = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 1'b1;

endpackage

>>> hdl/lob_if.sv
// Channel interfaces: request, response and configuration write.
// Depends on lob_pkg.
interface lob_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [lob_pkg::KEY_W-1:0]   order_key;
  logic                        bid_side;
  logic [lob_pkg::PRICE_W-1:0] order_price;
  logic [lob_pkg::QTY_W-1:0]   order_qty;
  modport source (output valid, req_type, order_key, bid_side, order_price, order_qty,
                  input ready);
  modport sink (input valid, req_type, order_key, bid_side, order_price, order_qty,
                output ready);
endinterface

interface lob_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lob_pkg::STAT_W-1:0]  status;
  logic                        bid_valid;
  logic [lob_pkg::PRICE_W-1:0] best_bid_price;
  logic [lob_pkg::TOT_W-1:0]   best_bid_total;
  logic                        ask_valid;
  logic [lob_pkg::PRICE_W-1:0] best_ask_price;
  logic [lob_pkg::TOT_W-1:0]   best_ask_total;
  modport source (output valid, status, bid_valid, best_bid_price, best_bid_total,
                  ask_valid, best_ask_price, best_ask_total, input ready);
  modport sink (input valid, status, bid_valid, best_bid_price, best_bid_total,
                ask_valid, best_ask_price, best_ask_total, output ready);
endinterface

interface lob_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lob_pkg::CFG_IDX_W-1:0] index;
  logic [lob_pkg::PRICE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/lob_best.sv
// Non-empty level bitmaps for both sides and a two-stage best-level search.
// Depends on lob_pkg.
module lob_best #(
  parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd_en,
  input  logic                            upd_bid,
  input  logic [$clog2(PRICE_LEVELS)-1:0] upd_idx,
  input  logic                            upd_set,
  input  logic                            srch_grp,
  input  logic                            srch_bit,
  output logic                            bid_ok,
  output logic [$clog2(PRICE_LEVELS)-1:0] bid_lvl,
  output logic                            ask_ok,
  output logic [$clog2(PRICE_LEVELS)-1:0] ask_lvl
);
  import lob_pkg::*;

  localparam int LVW  = $clog2(PRICE_LEVELS);
  localparam int GBW  = $clog2(GRP_BITS);
  localparam int NGRP = (PRICE_LEVELS + GRP_BITS - 1) / GRP_BITS;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NB   = NGRP * GRP_BITS;

  logic [NB-1:0]       bid_map_r, ask_map_r;
  logic [NGRP-1:0]     bid_grp, ask_grp;
  logic [GW-1:0]       bid_g, ask_g, bid_g_r, ask_g_r;
  logic [GRP_BITS-1:0] bid_word, ask_word;
  logic [GBW-1:0]      bid_b, ask_b;
  logic                bid_ok_r, ask_ok_r;
  logic [LVW-1:0]      bid_lvl_r, ask_lvl_r;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      bid_grp[g] = |bid_map_r[g*GRP_BITS +: GRP_BITS];
      ask_grp[g] = |ask_map_r[g*GRP_BITS +: GRP_BITS];
    end
  end

  // Highest non-empty bid group, lowest non-empty ask group
  always_comb begin
    bid_g = '0;
    ask_g = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (bid_grp[g]) bid_g = GW'(g);
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (ask_grp[g]) ask_g = GW'(g);
    end
  end

  assign bid_word = bid_map_r[bid_g_r*GRP_BITS +: GRP_BITS];
  assign ask_word = ask_map_r[ask_g_r*GRP_BITS +: GRP_BITS];

  always_comb begin
    bid_b = '0;
    ask_b = '0;
    for (int b = 0; b < GRP_BITS; b++) begin
      if (bid_word[b]) bid_b = GBW'(b);
    end
    for (int b = GRP_BITS - 1; b >= 0; b--) begin
      if (ask_word[b]) ask_b = GBW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_map_r <= '0;
      ask_map_r <= '0;
      bid_ok_r  <= 1'b0;
      ask_ok_r  <= 1'b0;
    end else begin
      if (upd_en) begin
        if (upd_bid) bid_map_r[upd_idx] <= upd_set;
        else         ask_map_r[upd_idx] <= upd_set;
      end
      if (srch_bit) begin
        bid_ok_r <= |bid_grp;
        ask_ok_r <= |ask_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (srch_grp) begin
      bid_g_r <= bid_g;
      ask_g_r <= ask_g;
    end
    if (srch_bit) begin
      bid_lvl_r <= LVW'({bid_g_r, bid_b});
      ask_lvl_r <= LVW'({ask_g_r, ask_b});
    end
  end

  assign bid_ok  = bid_ok_r;
  assign ask_ok  = ask_ok_r;
  assign bid_lvl = bid_lvl_r;
  assign ask_lvl = ask_lvl_r;

endmodule

>>> hdl/limit_order_book_engine.sv
// Limit order book engine: node pool, key map and per-level FIFO lists in
// block memories, with a sequencer per request. Depends on lob_pkg, lob_if, lob_best.
//
// Usage:
//  in_req  - one request beat (add, modify, cancel) per accepted handshake.
//  out_rsp - one response beat per request: status plus best bid / best ask
//            price and total quantity at those levels.
//  cfg_wr  - register writes (lowest_price, highest_price); always ready,
//            write only while no request is outstanding.
// A bad key or an unused request type goes straight to the bitmap search;
// other requests walk their node, key and level accesses one after another
// through memories with one registered read port and one write port, then
// run the group and bit stages of the bitmap search and two level-total reads.
// After reset the engine runs a clearing pass that initializes the free list,
// key map and level heads; in_req.ready stays low during it.
// The response sits in an output register; a new request is accepted as soon
// as the sequencer is idle, and a finished response waits there for as long
// as the receiver stalls.
module limit_order_book_engine #(
  parameter int ORDER_CAP    = lob_pkg::ORDER_CAP_DEF,
  parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  lob_req_if.sink   in_req,
  lob_rsp_if.source out_rsp,
  lob_cfg_if.sink   cfg_wr
);
  import lob_pkg::*;

  localparam int NA     = $clog2(ORDER_CAP);
  localparam int IW     = NA + 1;
  localparam int LVW    = $clog2(PRICE_LEVELS);
  localparam int LA     = LVW + 1;
  localparam int LDEPTH = 2 ** LA;
  localparam int CLR_N  = (ORDER_CAP > LDEPTH) ? ORDER_CAP : LDEPTH;
  localparam int CW     = $clog2(CLR_N + 1);
  localparam logic [IW-1:0] NIL = IW'(ORDER_CAP);

  typedef struct packed {
    logic [LVW-1:0]   lvl;
    logic [QTY_W-1:0] qty;
    logic             bid;
    logic [IW-1:0]    nxt;
    logic [IW-1:0]    prv;
  } node_t;

  typedef struct packed {
    logic [IW-1:0]    head;
    logic [IW-1:0]    tail;
    logic [TOT_W-1:0] total;
  } lvl_t;

  typedef enum logic [25:0] {
    S_CLR  = 26'h0000001, S_IDLE = 26'h0000002, S_KEY  = 26'h0000004,
    S_KEYD = 26'h0000008, S_NRD  = 26'h0000010, S_NDAT = 26'h0000020,
    S_UP   = 26'h0000040, S_UPW  = 26'h0000080, S_UX   = 26'h0000100,
    S_UXW  = 26'h0000200, S_UL   = 26'h0000400, S_ULW  = 26'h0000800,
    S_CFIN = 26'h0001000, S_LL   = 26'h0002000, S_LD   = 26'h0004000,
    S_TR   = 26'h0008000, S_TW   = 26'h0010000, S_LN   = 26'h0020000,
    S_SL   = 26'h0040000, S_SW   = 26'h0080000, S_SR1  = 26'h0100000,
    S_SR2  = 26'h0200000, S_TB   = 26'h0400000, S_TA   = 26'h0800000,
    S_TAD  = 26'h1000000, S_OUT  = 26'h2000000
  } state_t;

  // Memories
  node_t         node_mem [ORDER_CAP];
  logic [IW-1:0] key_mem  [ORDER_CAP];
  lvl_t          lvl_mem  [LDEPTH];

  node_t         node_q, node_wd;
  logic [NA-1:0] node_ra, node_wa;
  logic          node_we;
  logic [IW-1:0] key_q, key_wd;
  logic [NA-1:0] key_ra, key_wa;
  logic          key_we;
  lvl_t          lvl_q, lvl_wd;
  logic [LA-1:0] lvl_ra, lvl_wa;
  logic          lvl_we;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r;
  req_type_t          typ_r;
  logic [KEY_W-1:0]   key_r;
  logic               side_r;
  logic [LVW-1:0]     lv_r;
  logic               pbad_r;
  logic [QTY_W-1:0]   qty_r;
  logic [IW-1:0]      n_r, free_r, nfree_r;
  node_t              nd_r;
  status_t            status_r;
  logic [PRICE_W-1:0] low_r, high_r;
  logic [TOT_W-1:0]   bid_tot_r, ask_tot_r;

  logic               out_valid_r, out_bv_r, out_av_r;
  logic [STAT_W-1:0]  out_st_r;
  logic [PRICE_W-1:0] out_bp_r, out_ap_r;
  logic [TOT_W-1:0]   out_bt_r, out_at_r;

  logic               key_bad, accept, ld_empty;
  logic [PRICE_W-1:0] price_off;
  logic               price_bad;

  logic               upd_en, upd_bid, upd_set, srch_grp, srch_bit;
  logic [LVW-1:0]     upd_idx;
  logic               bid_ok, ask_ok;
  logic [LVW-1:0]     bid_lvl, ask_lvl;

  lob_best #(.PRICE_LEVELS(PRICE_LEVELS)) u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (upd_en),
    .upd_bid  (upd_bid),
    .upd_idx  (upd_idx),
    .upd_set  (upd_set),
    .srch_grp (srch_grp),
    .srch_bit (srch_bit),
    .bid_ok   (bid_ok),
    .bid_lvl  (bid_lvl),
    .ask_ok   (ask_ok),
    .ask_lvl  (ask_lvl)
  );

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_q <= node_mem[node_ra];
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[key_ra];
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_q <= lvl_mem[lvl_ra];
  end

  assign accept    = in_req.valid && in_req.ready;
  assign key_bad   = {1'b0, in_req.order_key} >= (KEY_W + 1)'(ORDER_CAP);
  assign price_off = in_req.order_price - low_r;
  assign price_bad = (in_req.order_price < low_r) || (in_req.order_price > high_r) ||
                     (price_off >= PRICE_W'(PRICE_LEVELS));
  assign ld_empty  = (lvl_q.head == NIL) || (lvl_q.tail == NIL);

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    node_we   = 1'b0;
    node_wa   = n_r[NA-1:0];
    node_wd   = nd_r;
    node_ra   = n_r[NA-1:0];
    key_we    = 1'b0;
    key_wa    = key_r[NA-1:0];
    key_wd    = NIL;
    key_ra    = key_r[NA-1:0];
    lvl_we    = 1'b0;
    lvl_wa    = {nd_r.bid, nd_r.lvl};
    lvl_wd    = lvl_q;
    lvl_ra    = {nd_r.bid, nd_r.lvl};
    upd_en    = 1'b0;
    upd_bid   = nd_r.bid;
    upd_idx   = nd_r.lvl;
    upd_set   = 1'b1;
    srch_grp  = 1'b0;
    srch_bit  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        node_we     = cnt_r < CW'(ORDER_CAP);
        node_wa     = cnt_r[NA-1:0];
        node_wd     = '0;
        node_wd.nxt = IW'(cnt_r) + 1'b1;
        key_we      = cnt_r < CW'(ORDER_CAP);
        key_wa      = cnt_r[NA-1:0];
        lvl_we      = cnt_r < CW'(LDEPTH);
        lvl_wa      = cnt_r[LA-1:0];
        lvl_wd      = '{head: NIL, tail: NIL, total: '0};
        if (cnt_r == CW'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (key_bad || req_type_t'(in_req.req_type) == REQ_RSVD) state_nxt = S_SR1;
          else state_nxt = S_KEY;
        end
      end
      S_KEY: state_nxt = S_KEYD;
      S_KEYD: begin
        if (typ_r == REQ_CANCEL) begin
          state_nxt = (key_q == NIL) ? S_SR1 : S_NRD;
        end else if (pbad_r) begin
          state_nxt = S_SR1;
        end else if (typ_r == REQ_ADD) begin
          state_nxt = (key_q != NIL || free_r == NIL) ? S_SR1 : S_NRD;
        end else begin
          state_nxt = (key_q == NIL) ? S_SR1 : S_NRD;
        end
      end
      S_NRD: state_nxt = S_NDAT;
      S_NDAT: begin
        if (typ_r == REQ_ADD) state_nxt = S_LL;
        else if (typ_r == REQ_MOD && node_q.lvl == lv_r) state_nxt = S_SL;
        else state_nxt = S_UP;
      end
      // unlink: fix neighbors, then the level entry
      S_UP: begin
        node_ra   = nd_r.prv[NA-1:0];
        state_nxt = (nd_r.prv != NIL) ? S_UPW : S_UX;
      end
      S_UPW: begin
        node_we     = 1'b1;
        node_wa     = nd_r.prv[NA-1:0];
        node_wd     = node_q;
        node_wd.nxt = nd_r.nxt;
        state_nxt   = S_UX;
      end
      S_UX: begin
        node_ra   = nd_r.nxt[NA-1:0];
        state_nxt = (nd_r.nxt != NIL) ? S_UXW : S_UL;
      end
      S_UXW: begin
        node_we     = 1'b1;
        node_wa     = nd_r.nxt[NA-1:0];
        node_wd     = node_q;
        node_wd.prv = nd_r.prv;
        state_nxt   = S_UL;
      end
      S_UL: state_nxt = S_ULW;
      S_ULW: begin
        lvl_we       = 1'b1;
        lvl_wd.head  = (nd_r.prv == NIL) ? nd_r.nxt : lvl_q.head;
        lvl_wd.tail  = (nd_r.nxt == NIL) ? nd_r.prv : lvl_q.tail;
        lvl_wd.total = lvl_q.total - TOT_W'(nd_r.qty);
        upd_en       = 1'b1;
        upd_set      = (nd_r.prv == NIL) ? (nd_r.nxt != NIL) : (lvl_q.head != NIL);
        state_nxt    = (typ_r == REQ_CANCEL) ? S_CFIN : S_LL;
      end
      S_CFIN: begin
        node_we     = 1'b1;
        node_wd.nxt = free_r;
        key_we      = 1'b1;
        state_nxt   = S_SR1;
      end
      // link at the tail of the level
      S_LL: state_nxt = S_LD;
      S_LD: begin
        lvl_we       = 1'b1;
        lvl_wd.head  = ld_empty ? n_r : lvl_q.head;
        lvl_wd.tail  = n_r;
        lvl_wd.total = lvl_q.total + TOT_W'(nd_r.qty);
        upd_en       = 1'b1;
        state_nxt    = ld_empty ? S_LN : S_TR;
      end
      S_TR: begin
        node_ra   = nd_r.prv[NA-1:0];
        state_nxt = S_TW;
      end
      S_TW: begin
        node_we     = 1'b1;
        node_wa     = nd_r.prv[NA-1:0];
        node_wd     = node_q;
        node_wd.nxt = n_r;
        state_nxt   = S_LN;
      end
      S_LN: begin
        node_we   = 1'b1;
        key_we    = (typ_r == REQ_ADD);
        key_wd    = n_r;
        state_nxt = S_SR1;
      end
      // same-price modify: adjust the level total and the node quantity
      S_SL: state_nxt = S_SW;
      S_SW: begin
        lvl_we       = 1'b1;
        lvl_wd.total = lvl_q.total - TOT_W'(nd_r.qty) + TOT_W'(qty_r);
        node_we      = 1'b1;
        node_wd.qty  = qty_r;
        state_nxt    = S_SR1;
      end
      S_SR1: begin
        srch_grp  = 1'b1;
        state_nxt = S_SR2;
      end
      S_SR2: begin
        srch_bit  = 1'b1;
        state_nxt = S_TB;
      end
      S_TB: begin
        lvl_ra    = {1'b1, bid_lvl};
        state_nxt = S_TA;
      end
      S_TA: begin
        lvl_ra    = {1'b0, ask_lvl};
        state_nxt = S_TAD;
      end
      S_TAD: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_rsp.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      low_r       <= LOWEST_RST;
      high_r      <= HIGHEST_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid) begin
        if (cfg_wr.index == CFG_LOWEST) low_r  <= cfg_wr.data;
        else                            high_r <= cfg_wr.data;
      end
      // S_OUT reloads the register itself
      if (out_valid_r && out_rsp.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: cnt_r <= cnt_r + 1'b1;
        S_IDLE: begin
          if (accept) begin
            typ_r    <= req_type_t'(in_req.req_type);
            key_r    <= in_req.order_key;
            side_r   <= in_req.bid_side;
            lv_r     <= price_off[LVW-1:0];
            pbad_r   <= price_bad;
            qty_r    <= in_req.order_qty;
            status_r <= key_bad ? ST_BAD_KEY : ST_OK;
          end
        end
        S_KEYD: begin
          n_r <= (typ_r == REQ_ADD) ? free_r : key_q;
          if (typ_r == REQ_CANCEL) begin
            if (key_q == NIL) status_r <= ST_NOT_LIVE;
          end else if (pbad_r) begin
            status_r <= ST_BAD_PRICE;
          end else if (typ_r == REQ_ADD) begin
            if (key_q != NIL)       status_r <= ST_LIVE;
            else if (free_r == NIL) status_r <= ST_POOL_FULL;
          end else if (key_q == NIL) begin
            status_r <= ST_NOT_LIVE;
          end
        end
        S_NDAT: begin
          nd_r <= node_q;
          if (typ_r == REQ_ADD) begin
            nfree_r  <= node_q.nxt;
            nd_r.lvl <= lv_r;
            nd_r.qty <= qty_r;
            nd_r.bid <= side_r;
          end
        end
        S_ULW: begin
          if (typ_r == REQ_MOD) begin
            nd_r.lvl <= lv_r;
            nd_r.qty <= qty_r;
          end
        end
        S_CFIN: free_r <= n_r;
        S_LD: begin
          nd_r.nxt <= NIL;
          nd_r.prv <= ld_empty ? NIL : lvl_q.tail;
        end
        S_LN: begin
          if (typ_r == REQ_ADD) free_r <= nfree_r;
        end
        S_TA:  bid_tot_r <= lvl_q.total;
        S_TAD: ask_tot_r <= lvl_q.total;
        S_OUT: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= status_r;
            out_bv_r    <= bid_ok;
            out_bp_r    <= bid_ok ? low_r + PRICE_W'(bid_lvl) : '0;
            out_bt_r    <= bid_ok ? bid_tot_r : '0;
            out_av_r    <= ask_ok;
            out_ap_r    <= ask_ok ? low_r + PRICE_W'(ask_lvl) : '0;
            out_at_r    <= ask_ok ? ask_tot_r : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_st_r;
  assign out_rsp.bid_valid      = out_bv_r;
  assign out_rsp.best_bid_price = out_bp_r;
  assign out_rsp.best_bid_total = out_bt_r;
  assign out_rsp.ask_valid      = out_av_r;
  assign out_rsp.best_ask_price = out_ap_r;
  assign out_rsp.best_ask_total = out_at_r;

endmodule

>>> test/tb.sv
// Testbench for limit_order_book_engine: directed and random add/modify/cancel
// traffic, checked beat by beat against a behavioral order book model.
// Depends on lob_pkg, lob_if and limit_order_book_engine.
`timescale 1ns / 100ps

module tb;
  import lob_pkg::*;

  localparam int NORD = ORDER_CAP_DEF;
  localparam int NLVL = PRICE_LEVELS_DEF;
  localparam int NILN = NORD;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               bid_valid;
    logic [PRICE_W-1:0] bid_price;
    logic [TOT_W-1:0]   bid_total;
    logic               ask_valid;
    logic [PRICE_W-1:0] ask_price;
    logic [TOT_W-1:0]   ask_total;
  } book_top_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   hold_off;
  book_top_t book_q[$];

  lob_req_if in_req();
  lob_rsp_if out_rsp();
  lob_cfg_if cfg_wr();

  limit_order_book_engine dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_wr(cfg_wr.sink)
  );

  // Book model state
  logic [PRICE_W-1:0] lo_px, hi_px;
  int                 n_lvl[NORD];
  logic [QTY_W-1:0]   n_qty[NORD];
  bit                 n_bid[NORD];
  int                 n_nxt[NORD];
  int                 n_prv[NORD];
  int                 key_node[NORD];
  int                 head_b[NLVL], tail_b[NLVL], head_a[NLVL], tail_a[NLVL];
  logic [TOT_W-1:0]   tot_b[NLVL], tot_a[NLVL];
  int                 free_head;
  logic [NORD-1:0]    live_key;

  function automatic void book_reset();
    lo_px = LOWEST_RST;
    hi_px = HIGHEST_RST;
    for (int i = 0; i < NORD; i++) begin
      n_lvl[i] = 0; n_qty[i] = 0; n_bid[i] = 0; n_prv[i] = 0;
      n_nxt[i] = i + 1; key_node[i] = NILN;
    end
    for (int i = 0; i < NLVL; i++) begin
      head_b[i] = NILN; tail_b[i] = NILN; tot_b[i] = 0;
      head_a[i] = NILN; tail_a[i] = NILN; tot_a[i] = 0;
    end
    free_head = 0;
    live_key = '0;
  endfunction

  function automatic void unlink(int n);
    int lv, p, x;
    lv = n_lvl[n]; p = n_prv[n]; x = n_nxt[n];
    if (p < NILN) n_nxt[p] = x;
    else if (n_bid[n]) head_b[lv] = x;
    else head_a[lv] = x;
    if (x < NILN) n_prv[x] = p;
    else if (n_bid[n]) tail_b[lv] = p;
    else tail_a[lv] = p;
    if (n_bid[n]) tot_b[lv] = tot_b[lv] - n_qty[n];
    else tot_a[lv] = tot_a[lv] - n_qty[n];
  endfunction

  function automatic void link(int n);
    int lv, t, h;
    lv = n_lvl[n];
    t = n_bid[n] ? tail_b[lv] : tail_a[lv];
    h = n_bid[n] ? head_b[lv] : head_a[lv];
    n_nxt[n] = NILN;
    if (h >= NILN || t >= NILN) begin
      n_prv[n] = NILN;
      if (n_bid[n]) head_b[lv] = n; else head_a[lv] = n;
    end else begin
      n_prv[n] = t;
      n_nxt[t] = n;
    end
    if (n_bid[n]) begin
      tail_b[lv] = n; tot_b[lv] = tot_b[lv] + n_qty[n];
    end else begin
      tail_a[lv] = n; tot_a[lv] = tot_a[lv] + n_qty[n];
    end
  endfunction

  function automatic status_t book_apply(req_type_t op, int key, bit bid,
                                         logic [PRICE_W-1:0] px, logic [QTY_W-1:0] qty);
    int n, lv;
    logic [32:0] off;
    if (key >= NORD) return ST_BAD_KEY;
    if (op == REQ_RSVD) return ST_OK;
    n = key_node[key];
    if (op == REQ_CANCEL) begin
      if (n >= NILN) return ST_NOT_LIVE;
      unlink(n);
      n_nxt[n] = free_head;
      free_head = n;
      key_node[key] = NILN;
      live_key[key] = 0;
      return ST_OK;
    end
    if (px < lo_px || px > hi_px) return ST_BAD_PRICE;
    off = {1'b0, px} - {1'b0, lo_px};
    if (off >= NLVL) return ST_BAD_PRICE;
    lv = int'(off);
    if (op == REQ_ADD) begin
      if (n < NILN) return ST_LIVE;
      n = free_head;
      if (n >= NILN) return ST_POOL_FULL;
      free_head = n_nxt[n];
      n_lvl[n] = lv; n_qty[n] = qty; n_bid[n] = bid;
      link(n);
      key_node[key] = n;
      live_key[key] = 1;
      return ST_OK;
    end
    if (n >= NILN) return ST_NOT_LIVE;
    if (n_lvl[n] == lv) begin
      if (n_bid[n]) tot_b[lv] = tot_b[lv] - n_qty[n] + qty;
      else tot_a[lv] = tot_a[lv] - n_qty[n] + qty;
      n_qty[n] = qty;
      return ST_OK;
    end
    unlink(n);
    n_lvl[n] = lv; n_qty[n] = qty;
    link(n);
    return ST_OK;
  endfunction

  function automatic book_top_t book_step(req_type_t op, int key, bit bid,
                                          logic [PRICE_W-1:0] px, logic [QTY_W-1:0] qty);
    book_top_t r;
    r = '0;
    r.status = book_apply(op, key, bid, px, qty);
    for (int i = NLVL - 1; i >= 0; i--) begin
      if (head_b[i] < NILN) begin
        r.bid_valid = 1; r.bid_price = lo_px + i; r.bid_total = tot_b[i];
        break;
      end
    end
    for (int i = 0; i < NLVL; i++) begin
      if (head_a[i] < NILN) begin
        r.ask_valid = 1; r.ask_price = lo_px + i; r.ask_total = tot_a[i];
        break;
      end
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Send one request beat after a random gap; predict at accept.
  // Valid stays up after the beat until the next gap or drain drops it.
  task automatic send_req(req_type_t op, int key, bit bid, logic [PRICE_W-1:0] px,
                          logic [QTY_W-1:0] qty);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1;
    in_req.req_type <= op;
    in_req.order_key <= key[KEY_W-1:0];
    in_req.bid_side <= bid;
    in_req.order_price <= px;
    in_req.order_qty <= qty;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    book_q.push_back(book_step(op, key, bid, px, qty));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_req.valid <= 0;
    while (book_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PRICE_W-1:0] val);
    cfg_wr.valid <= 1;
    cfg_wr.index <= idx;
    cfg_wr.data <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 0;
    if (idx == CFG_LOWEST) lo_px = val; else hi_px = val;
    @(posedge clk);
  endtask

  // Result checker: compares each accepted response beat with the model
  always @(posedge clk) begin
    book_top_t got, exp;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = {out_rsp.status, out_rsp.bid_valid, out_rsp.best_bid_price,
             out_rsp.best_bid_total, out_rsp.ask_valid, out_rsp.best_ask_price,
             out_rsp.best_ask_total};
      if (book_q.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        errors++;
      end else begin
        exp = book_q.pop_front();
        if (got.status !== exp.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp.status, got.status);
          errors++;
        end
        if (got.bid_valid !== exp.bid_valid || got.bid_price !== exp.bid_price ||
            got.bid_total !== exp.bid_total) begin
          $display("%0t bid: expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                   exp.bid_valid, exp.bid_price, exp.bid_total,
                   got.bid_valid, got.bid_price, got.bid_total);
          errors++;
        end
        if (got.ask_valid !== exp.ask_valid || got.ask_price !== exp.ask_price ||
            got.ask_total !== exp.ask_total) begin
          $display("%0t ask: expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                   exp.ask_valid, exp.ask_price, exp.ask_total,
                   got.ask_valid, got.ask_price, got.ask_total);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per beat, or a long hold-off on request.
  initial begin
    int stall;
    out_rsp.ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off > 0) begin
        out_rsp.ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_rsp.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1;
      @(posedge clk);
      while (!out_rsp.valid) @(posedge clk);
    end
  end

  function automatic logic [QTY_W-1:0] rand_qty();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return {QTY_W{1'b1}};
      default: return QTY_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_req(REQ_ADD, 0, 1, 10, 100);
    send_req(REQ_ADD, 1, 0, 20, {QTY_W{1'b1}});
    send_req(REQ_ADD, 2, 1, 10, 0);                // zero quantity joins level
    send_req(REQ_ADD, 0, 1, 11, 5);                // key already live
    send_req(REQ_ADD, NORD - 1, 0, 4095, 7);
    send_req(REQ_ADD, 3, 1, 4096, 7);              // above highest
    send_req(REQ_ADD, 16'hFFFF, 1, 5, 7);          // bad key
    send_req(REQ_MOD, 0, 0, 10, 55);               // same level, quantity only
    send_req(REQ_MOD, 0, 0, 30, 66);               // move level
    send_req(REQ_MOD, 9, 0, 30, 66);               // not live
    send_req(REQ_MOD, 2, 1, 32'hFFFF_FFFF, 1);     // bad price
    send_req(REQ_CANCEL, 9, 0, 0, 0);
    send_req(REQ_CANCEL, 2, 1, 32'hFFFF_FFFF, {QTY_W{1'b1}});
    send_req(REQ_RSVD, 4, 1, 32'hFFFF_FFFF, 3);
    send_req(REQ_RSVD, 16'hFFFF, 0, 0, 0);
    send_req(REQ_ADD, 5, 1, 0, {QTY_W{1'b1}});
    send_req(REQ_ADD, 6, 1, 0, {QTY_W{1'b1}});     // totals beyond 31 bits
    send_req(REQ_CANCEL, 0, 0, 0, 0);
    send_req(REQ_CANCEL, 1, 0, 0, 0);
    drain();
  endtask

  // Mostly well-formed traffic over a small key range: modify or cancel for live keys, add otherwise.
  task automatic test_random(int count, int key_span, int lvl_span);
    int k, r;
    req_type_t op;
    logic [PRICE_W-1:0] px;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, key_span - 1);
      px = lo_px + $urandom_range(0, lvl_span - 1);
      if (r < 3) px = $urandom;
      if (r >= 3 && r < 5) k = $urandom_range(NORD, 65535);
      if (live_key[k]) op = ($urandom_range(0, 9) < 6) ? REQ_MOD : REQ_CANCEL;
      else op = REQ_ADD;
      if (r >= 95) op = req_type_t'($urandom_range(0, 3));
      send_req(op, k, $urandom_range(0, 1), px, rand_qty());
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    test_random(60, 32, 8);
  endtask

  task automatic test_registers();
    write_reg(CFG_LOWEST, 32'hFFFF_F000);
    write_reg(CFG_HIGHEST, 32'hFFFF_FFFF);
    test_random(300, 64, 4096);
    write_reg(CFG_LOWEST, 1000);
    write_reg(CFG_HIGHEST, 1010);
    test_random(300, 48, 16);
    write_reg(CFG_LOWEST, 0);
    write_reg(CFG_HIGHEST, 0);
    test_random(150, 16, 2);
    write_reg(CFG_HIGHEST, 32'hFFFF_FFFF);
    test_random(250, 64, 4096);
  endtask

  initial begin
    errors = 0;
    hold_off = 0;
    book_reset();
    rst_n = 0;
    in_req.valid = 0; in_req.req_type = REQ_ADD; in_req.order_key = 0;
    in_req.bid_side = 0; in_req.order_price = 0; in_req.order_qty = 0;
    cfg_wr.valid = 0; cfg_wr.index = CFG_LOWEST; cfg_wr.data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(600, 32, 8);
    test_backpressure();
    test_registers();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
